>>> rtl/core/mpct_pkg.sv
// ----------------------------------------------------------------------------
// mpct_pkg: shared types and constants of the mouse packet cursor tracker
// Holds the packet phase enum, the command handed from the byte front end to
// the cursor back end, and the register map of the configuration port.
// ----------------------------------------------------------------------------
`default_nettype none

package mpct_pkg;

    // Received byte and its flag bits
    localparam int BYTE_BITS = 8;
    localparam int SYNC_POS  = 3;
    localparam int LEFT_POS  = 0;

    // Configuration port
    localparam int APB_DATA_BITS = 32;
    localparam int APB_ADDR_BITS = 3;
    localparam int REG_SEL_POS   = 2;

    localparam logic REG_X_LIMIT = 1'b0;
    localparam logic REG_Y_LIMIT = 1'b1;

    localparam int X_LIMIT_RESET = 1024;
    localparam int Y_LIMIT_RESET = 768;

    // Position in the three-byte packet
    typedef enum logic [1:0] {
        PH_SYNC   = 2'd0,
        PH_XDELTA = 2'd1,
        PH_YDELTA = 2'd2
    } phase_t;

    // What the back end does with one byte
    typedef enum logic [1:0] {
        CMD_HOLD   = 2'd0,
        CMD_DROP   = 2'd1,
        CMD_PACKET = 2'd2
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t              kind;
        logic                   left;
        logic [BYTE_BITS-1:0]   dx;
        logic [BYTE_BITS-1:0]   dy;
    } cmd_t;

endpackage

`default_nettype wire

>>> rtl/core/mpct_front.sv
// ----------------------------------------------------------------------------
// mpct_front: byte classifier
// Tracks the packet phase, keeps the header and X delta bytes, and turns
// every accepted byte into one command for the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module mpct_front (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           accept,
    input  wire logic [mpct_pkg::BYTE_BITS-1:0] rx_byte,
    output mpct_pkg::cmd_t                      cmd
);
    import mpct_pkg::*;

    phase_t               phase_reg, phase_next;
    logic [BYTE_BITS-1:0] header_reg, header_next;
    logic [BYTE_BITS-1:0] xdelta_reg, xdelta_next;

    // Next state
    always_comb begin
        phase_next  = phase_reg;
        header_next = header_reg;
        xdelta_next = xdelta_reg;
        if (accept) begin
            case (phase_reg)
                PH_XDELTA: begin
                    xdelta_next = rx_byte;
                    phase_next  = PH_YDELTA;
                end
                PH_YDELTA: begin
                    phase_next = PH_SYNC;
                end
                default: begin
                    if (rx_byte[SYNC_POS]) begin
                        header_next = rx_byte;
                        phase_next  = PH_XDELTA;
                    end else begin
                        phase_next = PH_SYNC;
                    end
                end
            endcase
        end
    end

    // Command for the current byte
    always_comb begin
        cmd.left = header_reg[LEFT_POS];
        cmd.dx   = xdelta_reg;
        cmd.dy   = rx_byte;
        case (phase_reg)
            PH_XDELTA: cmd.kind = CMD_HOLD;
            PH_YDELTA: cmd.kind = CMD_PACKET;
            default:   cmd.kind = rx_byte[SYNC_POS] ? CMD_HOLD : CMD_DROP;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= PH_SYNC;
            header_reg <= '0;
            xdelta_reg <= '0;
        end else begin
            phase_reg  <= phase_next;
            header_reg <= header_next;
            xdelta_reg <= xdelta_next;
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/mpct_fifo.sv
// ----------------------------------------------------------------------------
// mpct_fifo: two-entry command queue
// Decouples the byte classifier from the cursor update so each side stalls
// on its own.
// ----------------------------------------------------------------------------
`default_nettype none

module mpct_fifo (
    input  wire logic    aclk,
    input  wire logic    aresetn,
    input  wire logic    wr_valid,
    output logic         wr_ready,
    input  wire mpct_pkg::cmd_t wr_data,
    output logic         rd_valid,
    input  wire logic    rd_ready,
    output mpct_pkg::cmd_t rd_data
);
    import mpct_pkg::*;

    cmd_t        entry_reg [2];
    logic        wr_ptr_reg, wr_ptr_next;
    logic        rd_ptr_reg, rd_ptr_next;
    logic [1:0]  count_reg, count_next;
    logic        push, pop;

    assign wr_ready = (count_reg != 2'd2);
    assign rd_valid = (count_reg != 2'd0);
    assign rd_data  = entry_reg[rd_ptr_reg];
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;

    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 2'd1;
        end else if (pop && !push) begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/mpct_back.sv
// ----------------------------------------------------------------------------
// mpct_back: cursor update and result register
// Applies one command per cycle, when not stalled, to the held position and
// button state, clamps against the limits and holds the result until taken.
// ----------------------------------------------------------------------------
`default_nettype none

module mpct_back #(
    parameter int COORD_BITS = 12
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  cmd_valid,
    output logic                       cmd_ready,
    input  wire mpct_pkg::cmd_t        cmd,
    input  wire logic [COORD_BITS-1:0] x_limit,
    input  wire logic [COORD_BITS-1:0] y_limit,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output logic                       m_packet_done,
    output logic                       m_byte_dropped,
    output logic [COORD_BITS-1:0]      m_cursor_x,
    output logic [COORD_BITS-1:0]      m_cursor_y,
    output logic                       m_left_down,
    output logic                       m_left_released,
    output logic                       m_moved
);
    import mpct_pkg::*;

    localparam int SUM_BITS = COORD_BITS + 2;

    logic [COORD_BITS-1:0]      pos_x_reg, pos_x_next;
    logic [COORD_BITS-1:0]      pos_y_reg, pos_y_next;
    logic                       left_reg, left_next;
    logic                       valid_reg;
    logic                       done_reg, dropped_reg, released_reg, moved_reg;
    logic                       done_next, dropped_next, released_next, moved_next;
    logic signed [SUM_BITS-1:0] sum_x, sum_y;
    logic [COORD_BITS-1:0]      clamp_x, clamp_y;
    logic                       take;

    assign cmd_ready = !valid_reg || m_ready;
    assign take      = cmd_valid && cmd_ready;

    // Add X, subtract Y (origin at top left), then clamp to [0, limit]
    always_comb begin
        sum_x = $signed({2'b00, pos_x_reg}) + SUM_BITS'($signed(cmd.dx));
        sum_y = $signed({2'b00, pos_y_reg}) - SUM_BITS'($signed(cmd.dy));
        if (sum_x[SUM_BITS-1]) begin
            clamp_x = '0;
        end else if (sum_x[SUM_BITS-2:0] > {1'b0, x_limit}) begin
            clamp_x = x_limit;
        end else begin
            clamp_x = sum_x[COORD_BITS-1:0];
        end
        if (sum_y[SUM_BITS-1]) begin
            clamp_y = '0;
        end else if (sum_y[SUM_BITS-2:0] > {1'b0, y_limit}) begin
            clamp_y = y_limit;
        end else begin
            clamp_y = sum_y[COORD_BITS-1:0];
        end
    end

    always_comb begin
        pos_x_next    = pos_x_reg;
        pos_y_next    = pos_y_reg;
        left_next     = left_reg;
        done_next     = 1'b0;
        dropped_next  = 1'b0;
        released_next = 1'b0;
        moved_next    = 1'b0;
        case (cmd.kind)
            CMD_PACKET: begin
                pos_x_next    = clamp_x;
                pos_y_next    = clamp_y;
                left_next     = cmd.left;
                done_next     = 1'b1;
                released_next = left_reg && !cmd.left;
                moved_next    = (cmd.dx != '0) || (cmd.dy != '0);
            end
            CMD_DROP: dropped_next = 1'b1;
            default:  ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            pos_x_reg <= '0;
            pos_y_reg <= '0;
            left_reg  <= 1'b0;
        end else begin
            if (take) begin
                valid_reg <= 1'b1;
                pos_x_reg <= pos_x_next;
                pos_y_reg <= pos_y_next;
                left_reg  <= left_next;
            end else if (m_ready) begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            done_reg     <= done_next;
            dropped_reg  <= dropped_next;
            released_reg <= released_next;
            moved_reg    <= moved_next;
        end
    end

    assign m_valid         = valid_reg;
    assign m_packet_done   = done_reg;
    assign m_byte_dropped  = dropped_reg;
    assign m_cursor_x      = pos_x_reg;
    assign m_cursor_y      = pos_y_reg;
    assign m_left_down     = left_reg;
    assign m_left_released = released_reg;
    assign m_moved         = moved_reg;

endmodule

`default_nettype wire

>>> rtl/core/mouse_packet_cursor_tracker.sv
// ----------------------------------------------------------------------------
// mouse_packet_cursor_tracker: mouse byte stream to cursor position
// Gathers three-byte mouse packets and tracks a clamped cursor position.
//
// Input channel (s_*): one received byte per beat on s_rx_byte. A first byte
// needs bit 3 set; any other first byte is dropped and reported as such.
// Result channel (m_*): exactly one result beat per input beat, in order.
// A beat that completes a packet carries the new position, the left button,
// a one-packet release pulse and the moved flag; other beats carry the held
// position and button with packet_done, left_released and moved low.
// Path: a byte is classified into the command queue, then the update registers
// the result beat. Throughput: one byte per cycle while s_ready is high; a
// two-entry command queue sits between the classifier and the update.
// Stall: the result is held in an output register; while the receiver
// stalls the queue keeps taking bytes until it holds two, then s_ready drops.
// Reset (aresetn low, synchronous): phase to sync search, position and
// button to 0, queue and output emptied, x_limit to 1024, y_limit to 768.
// Registers: x_limit at 0x0, y_limit at 0x4; write only while idle.
// ----------------------------------------------------------------------------
`default_nettype none

module mouse_packet_cursor_tracker #(
    parameter int COORD_BITS = 12
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    // Byte input
    input  wire logic                                s_valid,
    output logic                                     s_ready,
    input  wire logic [mpct_pkg::BYTE_BITS-1:0]      s_rx_byte,
    // Result output
    output logic                                     m_valid,
    input  wire logic                                m_ready,
    output logic                                     m_packet_done,
    output logic                                     m_byte_dropped,
    output logic [COORD_BITS-1:0]                    m_cursor_x,
    output logic [COORD_BITS-1:0]                    m_cursor_y,
    output logic                                     m_left_down,
    output logic                                     m_left_released,
    output logic                                     m_moved,
    // Configuration
    input  wire logic                                psel,
    input  wire logic                                penable,
    input  wire logic                                pwrite,
    input  wire logic [mpct_pkg::APB_ADDR_BITS-1:0]  paddr,
    input  wire logic [mpct_pkg::APB_DATA_BITS-1:0]  pwdata,
    output logic [mpct_pkg::APB_DATA_BITS-1:0]       prdata,
    output logic                                     pready
);
    import mpct_pkg::*;

    localparam logic [COORD_BITS-1:0] XLimReset = COORD_BITS'(X_LIMIT_RESET);
    localparam logic [COORD_BITS-1:0] YLimReset = COORD_BITS'(Y_LIMIT_RESET);

    logic [COORD_BITS-1:0] x_limit_reg;
    logic [COORD_BITS-1:0] y_limit_reg;
    logic                  cfg_write;
    logic                  reg_sel;

    cmd_t front_cmd;
    cmd_t q_cmd;
    logic q_valid;
    logic q_ready;
    logic in_accept;

    // ------------------------------------------------------------------
    // Configuration registers: zero wait state, write on the access phase
    // ------------------------------------------------------------------
    assign pready    = 1'b1;
    assign reg_sel   = paddr[REG_SEL_POS];
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            x_limit_reg <= XLimReset;
            y_limit_reg <= YLimReset;
        end else if (cfg_write) begin
            case (reg_sel)
                REG_X_LIMIT: x_limit_reg <= pwdata[COORD_BITS-1:0];
                REG_Y_LIMIT: y_limit_reg <= pwdata[COORD_BITS-1:0];
                default:     ;
            endcase
        end
    end

    // Read back zero-extended
    always_comb begin
        case (reg_sel)
            REG_X_LIMIT: prdata = APB_DATA_BITS'(x_limit_reg);
            REG_Y_LIMIT: prdata = APB_DATA_BITS'(y_limit_reg);
            default:     prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Front end: classify each byte into hold, drop or packet-complete
    // ------------------------------------------------------------------
    assign in_accept = s_valid && s_ready;

    mpct_front u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .accept  (in_accept),
        .rx_byte (s_rx_byte),
        .cmd     (front_cmd)
    );

    // Queue between the two halves; s_ready is simply "queue not full"
    mpct_fifo u_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_valid (s_valid),
        .wr_ready (s_ready),
        .wr_data  (front_cmd),
        .rd_valid (q_valid),
        .rd_ready (q_ready),
        .rd_data  (q_cmd)
    );

    // ------------------------------------------------------------------
    // Back end: advance cursor, clamp, register the result beat
    // ------------------------------------------------------------------
    mpct_back #(
        .COORD_BITS (COORD_BITS)
    ) u_back (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cmd_valid       (q_valid),
        .cmd_ready       (q_ready),
        .cmd             (q_cmd),
        .x_limit         (x_limit_reg),
        .y_limit         (y_limit_reg),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_packet_done   (m_packet_done),
        .m_byte_dropped  (m_byte_dropped),
        .m_cursor_x      (m_cursor_x),
        .m_cursor_y      (m_cursor_y),
        .m_left_down     (m_left_down),
        .m_left_released (m_left_released),
        .m_moved         (m_moved)
    );

    // ------------------------------------------------------------------
    // Checks
    // ------------------------------------------------------------------
    // A full queue only happens while the back end has work pending
    a_full_has_work: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (q_valid && m_valid))
        else $error("queue full without pending back-end work");

    // Release and motion flags only accompany a completed packet
    a_flags_need_packet: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_packet_done) |-> (!m_moved && !m_left_released))
        else $error("packet flags set on a non-packet beat");

    // A release pulse means the button now reads up
    a_release_up: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_left_released) |-> !m_left_down)
        else $error("release reported while button still down");

    // A dropped byte never completes a packet
    a_drop_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_byte_dropped) |-> !m_packet_done)
        else $error("beat both dropped and completed a packet");

endmodule

`default_nettype wire

>>> tb/mpct_result_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// mpct_result_checker: cursor result predictor and comparator
// Watches the byte channel, the result channel and the register port of the
// cursor tracker, keeps its own packet and cursor state, and compares every
// result beat field by field with the oldest predicted result.
// ----------------------------------------------------------------------------

module mpct_result_checker #(
    parameter int COORD_BITS = 12
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    input  logic                                 s_ready,
    input  logic [mpct_pkg::BYTE_BITS-1:0]       s_rx_byte,
    input  logic                                 m_valid,
    input  logic                                 m_ready,
    input  logic                                 m_packet_done,
    input  logic                                 m_byte_dropped,
    input  logic [COORD_BITS-1:0]                m_cursor_x,
    input  logic [COORD_BITS-1:0]                m_cursor_y,
    input  logic                                 m_left_down,
    input  logic                                 m_left_released,
    input  logic                                 m_moved,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [mpct_pkg::APB_ADDR_BITS-1:0]   paddr,
    input  logic [mpct_pkg::APB_DATA_BITS-1:0]   pwdata,
    input  logic                                 pready,
    input  logic                                 run_over,
    output int unsigned                          error_count = 0,
    output int unsigned                          outstanding = 0,
    output int unsigned                          packets_seen = 0,
    output int unsigned                          drops_seen = 0
);

    import mpct_pkg::*;

    typedef struct packed {
        logic                   packet_done;
        logic                   byte_dropped;
        logic [COORD_BITS-1:0]  cursor_x;
        logic [COORD_BITS-1:0]  cursor_y;
        logic                   left_down;
        logic                   left_released;
        logic                   moved;
    } cursor_result_t;

    phase_t                 pkt_phase;
    logic [BYTE_BITS-1:0]   hdr_byte;
    logic [BYTE_BITS-1:0]   dx_byte;
    logic [COORD_BITS-1:0]  cur_x;
    logic [COORD_BITS-1:0]  cur_y;
    logic [COORD_BITS-1:0]  x_lim;
    logic [COORD_BITS-1:0]  y_lim;
    logic                   btn_left;
    cursor_result_t         pending_results[$];
    bit                     leftover_reported = 1'b0;

    task automatic report_mismatch(input string msg);
        error_count++;
        if (error_count <= 30) begin
            $display("[%0t] mpct_result_checker: %s", $time, msg);
        end
    endtask

    task automatic check_field(input string name, input int unsigned got,
                               input int unsigned want);
        if (got != want) begin
            report_mismatch($sformatf("%s got %0d, expected %0d", name, got, want));
        end
    endtask

    function automatic logic [COORD_BITS-1:0] clamp_to(input int v,
                                                       input logic [COORD_BITS-1:0] lim);
        if (v < 0) return '0;
        if (v > int'(lim)) return lim;
        return COORD_BITS'(v);
    endfunction

    // Advance the packet state by one byte and build the result it causes.
    task automatic track_byte(input logic [BYTE_BITS-1:0] b, output cursor_result_t r);
        int   nx;
        int   ny;
        logic was_left;
        r = '0;
        case (pkt_phase)
            PH_XDELTA: begin
                dx_byte   = b;
                pkt_phase = PH_YDELTA;
            end
            PH_YDELTA: begin
                was_left        = btn_left;
                pkt_phase       = PH_SYNC;
                r.moved         = (dx_byte != '0) || (b != '0);
                // Y is subtracted: the screen origin sits at the top left.
                nx              = int'(cur_x) + int'($signed(dx_byte));
                ny              = int'(cur_y) - int'($signed(b));
                cur_x           = clamp_to(nx, x_lim);
                cur_y           = clamp_to(ny, y_lim);
                btn_left        = hdr_byte[LEFT_POS];
                r.left_released = was_left && !btn_left;
                r.packet_done   = 1'b1;
            end
            default: begin
                // Sync search; the unused phase code behaves the same way.
                if (b[SYNC_POS]) begin
                    hdr_byte  = b;
                    pkt_phase = PH_XDELTA;
                end else begin
                    r.byte_dropped = 1'b1;
                    pkt_phase      = PH_SYNC;
                end
            end
        endcase
        r.cursor_x  = cur_x;
        r.cursor_y  = cur_y;
        r.left_down = btn_left;
    endtask

    always @(posedge aclk) begin : scoreboard
        cursor_result_t got;
        cursor_result_t want;
        cursor_result_t predicted;
        if (!aresetn) begin
            pkt_phase = PH_SYNC;
            hdr_byte  = '0;
            dx_byte   = '0;
            cur_x     = '0;
            cur_y     = '0;
            btn_left  = 1'b0;
            x_lim     = COORD_BITS'(X_LIMIT_RESET);
            y_lim     = COORD_BITS'(Y_LIMIT_RESET);
            pending_results.delete();
            outstanding <= 0;
        end else begin
            if (psel && penable && pwrite && pready) begin
                if (paddr[REG_SEL_POS] == REG_Y_LIMIT) begin
                    y_lim = pwdata[COORD_BITS-1:0];
                end else begin
                    x_lim = pwdata[COORD_BITS-1:0];
                end
            end
            if (m_valid && m_ready) begin
                got = {m_packet_done, m_byte_dropped, m_cursor_x, m_cursor_y,
                       m_left_down, m_left_released, m_moved};
                if (pending_results.size() == 0) begin
                    report_mismatch("result beat with no result expected");
                end else begin
                    want = pending_results.pop_front();
                    check_field("packet_done", got.packet_done, want.packet_done);
                    check_field("byte_dropped", got.byte_dropped, want.byte_dropped);
                    check_field("cursor_x", got.cursor_x, want.cursor_x);
                    check_field("cursor_y", got.cursor_y, want.cursor_y);
                    check_field("left_down", got.left_down, want.left_down);
                    check_field("left_released", got.left_released, want.left_released);
                    check_field("moved", got.moved, want.moved);
                    if (want.packet_done) packets_seen++;
                    if (want.byte_dropped) drops_seen++;
                end
            end
            if (s_valid && s_ready) begin
                track_byte(s_rx_byte, predicted);
                pending_results.push_back(predicted);
            end
            if (run_over && !leftover_reported && pending_results.size() != 0) begin
                leftover_reported = 1'b1;
                report_mismatch($sformatf("%0d expected results never arrived",
                                          pending_results.size()));
            end
            outstanding <= pending_results.size();
        end
    end

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: testbench of the mouse packet cursor tracker
// Feeds directed and random mouse byte streams under several cursor limits
// and idling mixes; a checker beside the block predicts every result beat.
// ----------------------------------------------------------------------------

module tb_top;

    import mpct_pkg::*;

    localparam int COORD_BITS      = 12;
    localparam int RESET_CYCLES    = 11;
    localparam int ITEMS_PER_PHASE = 125;
    localparam int NUM_PHASES      = 6;
    localparam int TAIL_CYCLES     = 8;
    localparam int WATCHDOG_LIMIT  = 2000;

    // Directed stream, run at the reset limits from the reset position.
    localparam logic [BYTE_BITS-1:0] DIRECTED_BYTES [26] = '{
        8'h00, 8'hF7,           // first bytes without the sync bit: dropped
        8'h08, 8'h00, 8'h00,    // packet with no motion
        8'h09, 8'h7F, 8'h80,    // left down, largest positive x, most negative y
        8'h08, 8'h80, 8'h7F,    // left release, x clamps at 0
        8'hFF, 8'h01, 8'hFF,    // header with every bit set, one step each way
        8'h08, 8'h00, 8'h01,    // motion in y only
        8'h0C, 8'hF7, 8'h00,    // x delta without bit 3 is still a delta
        8'h09, 8'h00, 8'h00,    // press without motion
        8'h08, 8'h01, 8'h00     // release with motion in x only
    };

    logic                         aclk = 1'b0;
    logic                         aresetn = 1'b0;

    logic                         s_valid = 1'b0;
    logic                         s_ready;
    logic [BYTE_BITS-1:0]         s_rx_byte = '0;

    logic                         m_valid;
    logic                         m_ready = 1'b0;
    logic                         m_packet_done;
    logic                         m_byte_dropped;
    logic [COORD_BITS-1:0]        m_cursor_x;
    logic [COORD_BITS-1:0]        m_cursor_y;
    logic                         m_left_down;
    logic                         m_left_released;
    logic                         m_moved;

    logic                         psel = 1'b0;
    logic                         penable = 1'b0;
    logic                         pwrite = 1'b0;
    logic [APB_ADDR_BITS-1:0]     paddr = '0;
    logic [APB_DATA_BITS-1:0]     pwdata = '0;
    logic [APB_DATA_BITS-1:0]     prdata;
    logic                         pready;

    logic                         run_over = 1'b0;
    int unsigned                  error_count;
    int unsigned                  outstanding;
    int unsigned                  packets_seen;
    int unsigned                  drops_seen;

    int unsigned                  src_idle_pct = 0;
    int unsigned                  sink_stall_pct = 0;
    int unsigned                  bytes_sent = 0;
    int unsigned                  quiet_cycles = 0;

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    mouse_packet_cursor_tracker #(
        .COORD_BITS(COORD_BITS)
    ) i_dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_rx_byte       (s_rx_byte),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_packet_done   (m_packet_done),
        .m_byte_dropped  (m_byte_dropped),
        .m_cursor_x      (m_cursor_x),
        .m_cursor_y      (m_cursor_y),
        .m_left_down     (m_left_down),
        .m_left_released (m_left_released),
        .m_moved         (m_moved),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    mpct_result_checker #(
        .COORD_BITS(COORD_BITS)
    ) i_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_rx_byte       (s_rx_byte),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_packet_done   (m_packet_done),
        .m_byte_dropped  (m_byte_dropped),
        .m_cursor_x      (m_cursor_x),
        .m_cursor_y      (m_cursor_y),
        .m_left_down     (m_left_down),
        .m_left_released (m_left_released),
        .m_moved         (m_moved),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .pready          (pready),
        .run_over        (run_over),
        .error_count     (error_count),
        .outstanding     (outstanding),
        .packets_seen    (packets_seen),
        .drops_seen      (drops_seen)
    );

    // Receiver: stall each cycle with the chance the current phase asks for.
    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= sink_stall_pct);
    end

    // Watchdog: count cycles in which no beat moves on either channel.
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles == WATCHDOG_LIMIT) begin
            $display("tb_top: watchdog expired after %0d quiet cycles", WATCHDOG_LIMIT);
            $display("tb_top: done, errors");
            $finish;
        end
    end

    // Send one byte beat: idle at random first, then hold valid and payload
    // until the handshake. Valid is left high so a back-to-back beat follows.
    task automatic send_byte(input logic [BYTE_BITS-1:0] b);
        while ($urandom_range(99) < src_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_rx_byte <= b;
        do @(posedge aclk); while (!s_ready);
        bytes_sent++;
    endtask

    // Extremes and small moves so that small limits are hit from both sides,
    // with full-range values mixed in.
    function automatic logic [BYTE_BITS-1:0] pick_delta();
        case ($urandom_range(9))
            0: return 8'h00;
            1: return 8'h7F;
            2: return 8'h80;
            3: return 8'h01;
            4: return 8'hFF;
            5, 6: return BYTE_BITS'($urandom_range(8)) - 8'd4;
            default: return BYTE_BITS'($urandom);
        endcase
    endfunction

    // Well-formed packet: random header with the sync bit forced on.
    task automatic send_packet();
        logic [BYTE_BITS-1:0] hdr;
        hdr = BYTE_BITS'($urandom) | (BYTE_BITS'(1) << SYNC_POS);
        send_byte(hdr);
        send_byte(pick_delta());
        send_byte(pick_delta());
    endtask

    // Drop valid and hold off until every predicted result has come back.
    task automatic wait_drained();
        s_valid <= 1'b0;
        do @(posedge aclk); while (outstanding != 0);
    endtask

    // Write both limit registers back to back: setup beat, then access beat.
    // Upper data bits carry noise the block must ignore.
    task automatic set_limits(input logic [COORD_BITS-1:0] lim_x,
                              input logic [COORD_BITS-1:0] lim_y);
        logic [APB_DATA_BITS-1:0] word;
        logic                     idx;
        for (int i = 0; i < 2; i++) begin
            idx  = (i == 0) ? REG_X_LIMIT : REG_Y_LIMIT;
            word = $urandom;
            word[COORD_BITS-1:0] = (idx == REG_X_LIMIT) ? lim_x : lim_y;
            psel    <= 1'b1;
            penable <= 1'b0;
            pwrite  <= 1'b1;
            paddr   <= APB_ADDR_BITS'(idx) << REG_SEL_POS;
            pwdata  <= word;
            @(posedge aclk);
            penable <= 1'b1;
            do @(posedge aclk); while (!pready);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    initial begin : stimulus
        logic [COORD_BITS-1:0] lim_x;
        logic [COORD_BITS-1:0] lim_y;
        int unsigned           n;
        bit                    paused;
        paused = 1'b0;

        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed part at the reset limits.
        foreach (DIRECTED_BYTES[i]) send_byte(DIRECTED_BYTES[i]);
        wait_drained();

        for (int k = 0; k < NUM_PHASES; k++) begin
            // Idling mix: none, sender, receiver, both.
            case (k % 4)
                0: begin src_idle_pct = 0;  sink_stall_pct <= 0;  end
                1: begin src_idle_pct = 82; sink_stall_pct <= 0;  end
                2: begin src_idle_pct = 0;  sink_stall_pct <= 82; end
                default: begin src_idle_pct = 21; sink_stall_pct <= 21; end
            endcase
            // Limits: widest, then lowered below the held position, then
            // zero, random full range, random small, and one of each extreme.
            case (k)
                0: begin lim_x = '1; lim_y = '1; end
                1: begin lim_x = 12'd17; lim_y = 12'd9; end
                2: begin lim_x = '0; lim_y = '0; end
                3: begin
                    lim_x = COORD_BITS'($urandom);
                    lim_y = COORD_BITS'($urandom);
                end
                4: begin
                    lim_x = COORD_BITS'($urandom_range(64, 1));
                    lim_y = COORD_BITS'($urandom_range(64, 1));
                end
                default: begin lim_x = '1; lim_y = '0; end
            endcase
            set_limits(lim_x, lim_y);

            n = 0;
            while (n < ITEMS_PER_PHASE) begin
                // Hold off once mid-stream until the block has fully drained.
                if (k == 0 && n >= 60 && !paused) begin
                    wait_drained();
                    paused = 1'b1;
                end
                if ($urandom_range(99) < 85) begin
                    send_packet();
                    n += 3;
                end else begin
                    // Noise byte: may drop, or start a packet out of step.
                    send_byte(BYTE_BITS'($urandom));
                    n++;
                end
            end
            wait_drained();
        end

        // Let the checker flag leftovers and any stray late beat.
        run_over <= 1'b1;
        repeat (TAIL_CYCLES) @(posedge aclk);

        $display("tb_top: %0d bytes sent over %0d limit settings, %0d packets, %0d drops",
                 bytes_sent, NUM_PHASES + 1, packets_seen, drops_seen);
        $display("tb_top: idling mixes none, sender, receiver and both; limits 0 to 4095");
        if (error_count == 0) begin
            $display("tb_top: done, clean");
        end else begin
            $display("tb_top: done, errors");
        end
        $finish;
    end

endmodule
